// ===== design/khb_pkg.sv =====
// Shared constants, command codes and status struct of the keyed max-heap bank.
`timescale 1ns / 1ps
package khb_pkg;
	localparam int QUEUES      = 16;
	localparam int QUEUE_DEPTH = 256;
	localparam int KEY_BYTES   = 15;

	localparam int KEYW  = KEY_BYTES * 8;
	localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int DW    = $clog2(QUEUE_DEPTH);
	localparam int SZW   = DW + 1;
	localparam int ADDRW = QW + DW;
	localparam int RAMD  = 2 ** ADDRW;
	localparam int VALW  = 17;
	localparam int CNTW  = 16;
	localparam int SUMW  = 48;
	localparam logic [SUMW-1:0] SUM_MAX = '1;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef enum logic [3:0] {
		CMD_IDLE,
		CMD_START,
		CMD_UP_CHK,
		CMD_UP_CMP,
		CMD_POP_TEST,
		CMD_POP_TOP,
		CMD_POP_LAST,
		CMD_DN_L,
		CMD_DN_R,
		CMD_DN_CMP,
		CMD_RESULT
	} khb_cmd_t;

	typedef struct packed {
		logic is_pop;
		logic found;
		logic push_ok;
		logic i_zero;
		logic parent_ge;
		logic pop_more;
		logic dn_done;
		logic out_free;
	} khb_stat_t;
endpackage

// ===== design/khb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module khb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/khb_ctrl.sv =====
// Sequencer of the keyed max-heap bank: lookup, sift up, pop and sift down.
`timescale 1ns / 1ps
module khb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  khb_pkg::khb_stat_t stat,
	output khb_pkg::khb_cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_START, S_UP_CHK, S_UP_CMP, S_POP_TEST, S_POP_TOP,
		S_POP_LAST, S_DN_L, S_DN_R, S_DN_CMP, S_RESULT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:     if (in_valid) state_q <= S_START;
				S_START: begin
					if (stat.is_pop) state_q <= stat.found ? S_POP_TEST : S_RESULT;
					else state_q <= stat.push_ok ? S_UP_CHK : S_RESULT;
				end
				S_UP_CHK:   state_q <= stat.i_zero ? S_RESULT : S_UP_CMP;
				S_UP_CMP:   state_q <= stat.parent_ge ? S_RESULT : S_UP_CHK;
				S_POP_TEST: state_q <= stat.pop_more ? S_POP_TOP : S_RESULT;
				S_POP_TOP:  state_q <= S_POP_LAST;
				S_POP_LAST: state_q <= S_DN_L;
				S_DN_L:     state_q <= S_DN_R;
				S_DN_R:     state_q <= S_DN_CMP;
				S_DN_CMP:   state_q <= stat.dn_done ? S_POP_TEST : S_DN_L;
				S_RESULT:   if (stat.out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		unique case (state_q)
			S_IDLE:     cmd = khb_pkg::CMD_IDLE;
			S_START:    cmd = khb_pkg::CMD_START;
			S_UP_CHK:   cmd = khb_pkg::CMD_UP_CHK;
			S_UP_CMP:   cmd = khb_pkg::CMD_UP_CMP;
			S_POP_TEST: cmd = khb_pkg::CMD_POP_TEST;
			S_POP_TOP:  cmd = khb_pkg::CMD_POP_TOP;
			S_POP_LAST: cmd = khb_pkg::CMD_POP_LAST;
			S_DN_L:     cmd = khb_pkg::CMD_DN_L;
			S_DN_R:     cmd = khb_pkg::CMD_DN_R;
			S_DN_CMP:   cmd = khb_pkg::CMD_DN_CMP;
			S_RESULT:   cmd = khb_pkg::CMD_RESULT;
			default:    cmd = khb_pkg::CMD_IDLE;
		endcase
	end
endmodule

// ===== design/khb_dp.sv =====
// Datapath of the keyed max-heap bank: key table, sizes, heap RAM and result register.
`timescale 1ns / 1ps
module khb_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  khb_pkg::khb_cmd_t           cmd,
	output khb_pkg::khb_stat_t          stat,
	input  logic                        in_valid,
	input  logic                        func,
	input  logic [55:0]                 key_high,
	input  logic [63:0]                 key_low,
	input  logic [khb_pkg::VALW-1:0]    value,
	input  logic [khb_pkg::CNTW-1:0]    pop_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [khb_pkg::CNTW-1:0]    popped_count,
	output logic [khb_pkg::SUMW-1:0]    popped_sum,
	output logic [khb_pkg::SUMW-1:0]    running_total,
	output logic                        push_dropped
);
	localparam int QW  = khb_pkg::QW;
	localparam int DW  = khb_pkg::DW;
	localparam int SZW = khb_pkg::SZW;
	localparam int VW  = khb_pkg::VALW;
	localparam int SW  = khb_pkg::SUMW;

	logic [khb_pkg::KEYW-1:0] key_tab_q [khb_pkg::QUEUES];
	logic [khb_pkg::QUEUES-1:0] kvalid_q;
	logic [SZW-1:0] size_q [khb_pkg::QUEUES];

	logic                     func_q;
	logic [khb_pkg::KEYW-1:0] key_q;
	logic [VW-1:0]            val_q;
	logic [khb_pkg::CNTW-1:0] want_q, cnt_q;
	logic [SW-1:0]            sum_q, total_q;
	logic                     drop_q;
	logic [QW-1:0]            q_q;
	logic [DW-1:0]            i_q;
	logic [SZW-1:0]           n_q;
	logic [VW-1:0]            last_q, lv_q;
	logic                     out_valid_q;

	logic [119:0]             key_full;
	logic                     found, any_free, push_ok, out_free;
	logic [QW-1:0]            q_hit, q_free, q_sel;
	logic [SZW-1:0]           size_sel, size_cur, n_c;
	logic [DW+1:0]            l_c, r_c;
	logic [DW-1:0]            p_c, m_idx;
	logic                     has_l, has_r, m_moved;
	logic [VW-1:0]            mv, rdata;
	logic                     we;
	logic [khb_pkg::ADDRW-1:0] waddr, raddr;
	logic [VW-1:0]            wdata;
	logic [SW:0]              total_sum;

	assign key_full = {key_high, key_low};

	always_comb begin
		found = 1'b0;
		any_free = 1'b0;
		q_hit = '0;
		q_free = '0;
		for (int k = khb_pkg::QUEUES - 1; k >= 0; k--) begin
			if (kvalid_q[k] && key_tab_q[k] == key_q) begin
				found = 1'b1;
				q_hit = QW'(k);
			end
			if (!kvalid_q[k]) begin
				any_free = 1'b1;
				q_free = QW'(k);
			end
		end
	end

	assign q_sel    = found ? q_hit : q_free;
	assign size_sel = size_q[q_sel];
	assign push_ok  = found ? (size_sel < SZW'(khb_pkg::QUEUE_DEPTH)) : any_free;
	assign size_cur = size_q[q_q];
	assign n_c      = size_cur - SZW'(1);
	assign p_c      = (i_q - DW'(1)) >> 1;
	assign l_c      = {1'b0, i_q, 1'b1};
	assign r_c      = l_c + (DW+2)'(1);
	assign has_l    = l_c < {1'b0, n_q};
	assign has_r    = r_c < {1'b0, n_q};
	assign out_free = !out_valid_q || out_ready;

	// Pick the larger child against the value carried in the hole.
	always_comb begin
		mv = last_q;
		m_idx = i_q;
		m_moved = 1'b0;
		if (has_l && lv_q > mv) begin
			mv = lv_q;
			m_idx = l_c[DW-1:0];
			m_moved = 1'b1;
		end
		if (has_r && rdata > mv) begin
			mv = rdata;
			m_idx = r_c[DW-1:0];
			m_moved = 1'b1;
		end
	end

	assign total_sum = {1'b0, total_q} + {1'b0, sum_q};

	always_comb begin
		stat.is_pop    = (func_q == khb_pkg::FUNC_POP);
		stat.found     = found;
		stat.push_ok   = push_ok;
		stat.i_zero    = (i_q == '0);
		stat.parent_ge = (rdata >= val_q);
		stat.pop_more  = (cnt_q < want_q) && (size_cur != '0);
		stat.dn_done   = !m_moved;
		stat.out_free  = out_free;
	end

	always_comb begin
		we = 1'b0;
		waddr = {q_q, i_q};
		wdata = val_q;
		raddr = {q_q, p_c};
		case (cmd)
			khb_pkg::CMD_UP_CHK: begin
				we = (i_q == '0);
			end
			khb_pkg::CMD_UP_CMP: begin
				we = 1'b1;
				wdata = (rdata >= val_q) ? val_q : rdata;
			end
			khb_pkg::CMD_POP_TEST: raddr = {q_q, DW'(0)};
			khb_pkg::CMD_POP_TOP:  raddr = {q_q, n_c[DW-1:0]};
			khb_pkg::CMD_DN_L:     raddr = {q_q, l_c[DW-1:0]};
			khb_pkg::CMD_DN_R:     raddr = {q_q, r_c[DW-1:0]};
			khb_pkg::CMD_DN_CMP: begin
				we = 1'b1;
				wdata = mv;
			end
			default: ;
		endcase
	end

	khb_ram #(.WIDTH(VW), .DEPTH(khb_pkg::RAMD)) u_heap (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		case (cmd)
			khb_pkg::CMD_IDLE: begin
				if (in_valid) begin
					func_q <= func;
					key_q  <= key_full[khb_pkg::KEYW-1:0];
					val_q  <= value;
					want_q <= pop_count;
				end
			end
			khb_pkg::CMD_START: begin
				q_q   <= q_sel;
				cnt_q <= '0;
				sum_q <= '0;
				drop_q <= (func_q == khb_pkg::FUNC_PUSH) && !push_ok;
				i_q   <= found ? size_sel[DW-1:0] : '0;
				if (func_q == khb_pkg::FUNC_PUSH && push_ok && !found) begin
					key_tab_q[q_sel] <= key_q;
				end
			end
			khb_pkg::CMD_UP_CMP: if (rdata < val_q) i_q <= p_c;
			khb_pkg::CMD_POP_TOP: begin
				sum_q <= sum_q + SW'(rdata);
				cnt_q <= cnt_q + khb_pkg::CNTW'(1);
				n_q   <= n_c;
			end
			khb_pkg::CMD_POP_LAST: begin
				last_q <= rdata;
				i_q    <= '0;
			end
			khb_pkg::CMD_DN_R:   lv_q <= rdata;
			khb_pkg::CMD_DN_CMP: i_q <= m_idx;
			khb_pkg::CMD_RESULT: begin
				if (out_free) begin
					popped_count  <= cnt_q;
					popped_sum    <= sum_q;
					running_total <= total_q;
					push_dropped  <= drop_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kvalid_q    <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < khb_pkg::QUEUES; k++) begin
				size_q[k] <= '0;
			end
		end else begin
			case (cmd)
				khb_pkg::CMD_START: begin
					if (func_q == khb_pkg::FUNC_PUSH && push_ok) begin
						kvalid_q[q_sel] <= 1'b1;
						size_q[q_sel] <= (found ? size_sel : '0) + SZW'(1);
					end
				end
				khb_pkg::CMD_POP_TEST: begin
					if (!((cnt_q < want_q) && (size_cur != '0))) begin
						total_q <= total_sum[SW] ? khb_pkg::SUM_MAX : total_sum[SW-1:0];
					end
				end
				khb_pkg::CMD_POP_TOP: size_q[q_q] <= n_c;
				default: ;
			endcase
			if (cmd == khb_pkg::CMD_RESULT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== design/keyed_max_heap_bank_unit.sv =====
// Top level of the keyed max-heap bank: sequencer plus datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_ready  | func, key_high, key_low, value, pop_count
//  out     | out_valid / out_ready| popped_count, popped_sum, running_total, push_dropped
//
// Steps: one transaction at a time. A push looks the key up, then per level the value
// climbs (at most log2 of the queue depth) checks for the root and its parent; a pop,
// per value removed, reads the top and the last value, then both children per level
// the hole sinks. The single read port of the heap RAM paces both walks. A dropped
// push or a pop of an unknown key goes straight from the lookup to the result.
// Reset clears key valid bits, queue sizes and the total; heap RAM needs no clearing.
// The result sits in an output register: a stalled out channel blocks only the end of
// the next transaction, and in_ready rises as soon as the sequencer is idle.
`timescale 1ns / 1ps
module keyed_max_heap_bank_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic [55:0]              key_high,
	input  logic [63:0]              key_low,
	input  logic [khb_pkg::VALW-1:0] value,
	input  logic [khb_pkg::CNTW-1:0] pop_count,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [khb_pkg::CNTW-1:0] popped_count,
	output logic [khb_pkg::SUMW-1:0] popped_sum,
	output logic [khb_pkg::SUMW-1:0] running_total,
	output logic                     push_dropped
);
	khb_pkg::khb_cmd_t  cmd;
	khb_pkg::khb_stat_t stat;

	// Sequencer: walks lookup, sift-up and per-value sift-down steps.
	khb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: holds keys, sizes, heap RAM, totals and the result register.
	khb_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_valid      (in_valid),
		.func          (func),
		.key_high      (key_high),
		.key_low       (key_low),
		.value         (value),
		.pop_count     (pop_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.popped_count  (popped_count),
		.popped_sum    (popped_sum),
		.running_total (running_total),
		.push_dropped  (push_dropped)
	);
endmodule

// ===== design/khb_chk.sv =====
// Port-level checker of the keyed max-heap bank and its bind.
`timescale 1ns / 1ps
module khb_chk (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [khb_pkg::CNTW-1:0] popped_count,
	input logic [khb_pkg::SUMW-1:0] popped_sum,
	input logic [khb_pkg::SUMW-1:0] running_total,
	input logic                     push_dropped
);
	logic [khb_pkg::SUMW-1:0] prev_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_total_q <= '0;
		end else if (out_valid && out_ready) begin
			prev_total_q <= running_total;
		end
	end

	a_drop_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && push_dropped |-> popped_count == '0 && popped_sum == '0)
		else $error("dropped push reports popped values");

	a_zero_count_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && popped_count == '0 |-> popped_sum == '0)
		else $error("nonzero sum with zero count");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> running_total >= prev_total_q)
		else $error("running total decreased");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(running_total))
		else $error("stalled result changed");
endmodule

bind keyed_max_heap_bank_unit khb_chk u_khb_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.popped_count  (popped_count),
	.popped_sum    (popped_sum),
	.running_total (running_total),
	.push_dropped  (push_dropped)
);
